// File: rtl/ola_pkg.sv
// shared types and constants for the ordered list block
// no dependencies; used by ola_cell and ordered_list_append_remove
`default_nettype none

package ola_pkg;

  // default list capacity and fixed payload widths
  localparam int LIST_DEPTH_DEF = 32;
  localparam int VAL_W          = 32;
  localparam int KIND_W         = 2;
  localparam int STATUS_W       = 3;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // strobes broadcast from the controller to every cell
  typedef struct packed {
    logic append;   // cell at the tail slot loads the request value
    logic compare;  // cells latch their match flag against the request
    logic remove;   // cells at or past the first match take their neighbor's value
    logic rotate;   // whole row shifts toward the head, head wraps to the tail
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/ola_cell.sv
// one storage cell of the list chain: holds one entry, shifts toward the head
// depends on ola_pkg (cell_ctl_t, VAL_W)
`default_nettype none

module ola_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  wire                            clk,
  input  var ola_pkg::cell_ctl_t         ctl,
  input  wire        [CNT_W-1:0]         count,
  input  wire signed [ola_pkg::VAL_W-1:0] req_value,
  input  wire signed [ola_pkg::VAL_W-1:0] next_value,
  input  wire signed [ola_pkg::VAL_W-1:0] head_value,
  input  wire                            hit_in,
  output logic                           hit_out,
  output logic signed [ola_pkg::VAL_W-1:0] value
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

  logic signed [ola_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                             match_r, match_nxt;
  logic                             occupied;

  // slot holds a live entry
  assign occupied = (IDX_C < count);

  // first-match chain: this cell or an earlier one matched
  assign hit_out = hit_in | match_r;
  assign value   = value_r;

  // next entry value
  always_comb begin
    value_nxt = value_r;
    if (ctl.append && (IDX_C == count)) begin
      value_nxt = req_value;
    end else if (ctl.remove && hit_out) begin
      value_nxt = next_value;
    end else if (ctl.rotate) begin
      value_nxt = (IDX_P1 == count) ? head_value : next_value;
    end
  end

  // match flag for a pending remove
  always_comb begin
    match_nxt = match_r;
    if (ctl.compare) begin
      match_nxt = occupied && (value_r == req_value);
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    match_r <= match_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/ordered_list_append_remove.sv
// ordered list block: a chain of ola_cell entries driven by a small controller
// append, empty and full results are registered in the cycle after accept
// append: 1 word/cycle unless out_stall holds; no request taken in S_MATCH or S_DUMP
// dump rotates the entries once through the cell chain, restoring the order
// reset: entry count and controller cleared; cell contents are not cleared
// depends on ola_pkg and ola_cell
`default_nettype none

module ordered_list_append_remove #(
  parameter int LIST_DEPTH = ola_pkg::LIST_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire        [ola_pkg::KIND_W-1:0]  in_kind,
  input  wire signed [ola_pkg::VAL_W-1:0]   in_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic       [ola_pkg::STATUS_W-1:0] out_status,
  output logic signed [ola_pkg::VAL_W-1:0]  out_entry,
  output logic                              out_last
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_DUMP  = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [CNT_W-1:0]                 left_r, left_nxt;
  logic signed [ola_pkg::VAL_W-1:0] req_r, req_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [ola_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic signed [ola_pkg::VAL_W-1:0] out_entry_r, out_entry_nxt;
  logic                             out_last_r, out_last_nxt;
  logic                             out_load;
  logic                             out_free;
  logic                             in_acc;

  ola_pkg::cell_ctl_t               ctl;
  logic signed [ola_pkg::VAL_W-1:0] cell_val [LIST_DEPTH];
  logic signed [ola_pkg::VAL_W-1:0] next_val [LIST_DEPTH];
  logic [LIST_DEPTH:0]              hit;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_last   = out_last_r;

  // cell chain
  assign hit[0] = 1'b0;
  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      if (gi == LIST_DEPTH - 1) begin : g_tail
        assign next_val[gi] = cell_val[gi];
      end else begin : g_mid
        assign next_val[gi] = cell_val[gi+1];
      end
      ola_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .count      (count_r),
        .req_value  ((state_r == S_MATCH) ? req_r : in_value),
        .next_value (next_val[gi]),
        .head_value (cell_val[0]),
        .hit_in     (hit[gi]),
        .hit_out    (hit[gi+1]),
        .value      (cell_val[gi])
      );
    end
  endgenerate

  // controller
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    req_nxt        = req_r;
    ctl            = '0;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_entry_nxt = in_value;
          out_last_nxt  = 1'b1;
          case (in_kind)
            ola_pkg::KIND_APPEND: begin
              out_load = 1'b1;
              if (count_r == DEPTH_C) begin
                out_status_nxt = ola_pkg::ST_FULL;
              end else begin
                ctl.append     = 1'b1;
                count_nxt      = count_r + ONE_C;
                out_status_nxt = ola_pkg::ST_APPENDED;
              end
            end
            ola_pkg::KIND_REMOVE: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = ola_pkg::ST_EMPTY;
              end else begin
                ctl.compare = 1'b1;
                req_nxt     = in_value;
                state_nxt   = S_MATCH;
              end
            end
            ola_pkg::KIND_DUMP: begin
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_status_nxt = ola_pkg::ST_EMPTY;
              end else begin
                left_nxt  = count_r - ONE_C;
                state_nxt = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MATCH: begin
        // output register is empty here: nothing was loaded at accept
        ctl.remove    = 1'b1;
        out_load      = 1'b1;
        out_entry_nxt = req_r;
        out_last_nxt  = 1'b1;
        if (hit[LIST_DEPTH]) begin
          count_nxt      = count_r - ONE_C;
          out_status_nxt = ola_pkg::ST_REMOVED;
        end else begin
          out_status_nxt = ola_pkg::ST_NOT_FOUND;
        end
        state_nxt = S_IDLE;
      end
      S_DUMP: begin
        if (out_free) begin
          ctl.rotate     = 1'b1;
          out_load       = 1'b1;
          out_status_nxt = ola_pkg::ST_APPENDED;
          out_entry_nxt  = cell_val[0];
          out_last_nxt   = (left_r == '0);
          if (left_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            left_nxt = left_r - ONE_C;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    left_r       <= left_nxt;
    req_r        <= req_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above list depth");

  a_match_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MATCH) |-> !out_valid_r)
    else $error("output word pending while resolving remove");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind == ola_pkg::KIND_APPEND) && (count_r != DEPTH_C))
      |=> (count_r == $past(count_r) + ONE_C))
    else $error("append did not grow the list");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> (count_r == $past(count_r)))
    else $error("entry count changed during dump");

  a_dump_last_exits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DUMP) && out_load && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("dump did not end after tail word");

endmodule

`default_nettype wire

// File: verif/ordered_list_checker.sv
// checker for the ordered list block: keeps a shadow list, predicts result words
// and compares them with the words the block hands out
// depends on ola_pkg
module ordered_list_checker #(
  parameter int LIST_DEPTH = ola_pkg::LIST_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  wire        [ola_pkg::KIND_W-1:0]   in_kind,
  input  wire signed [ola_pkg::VAL_W-1:0]    in_value,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire        [ola_pkg::STATUS_W-1:0] out_status,
  input  wire signed [ola_pkg::VAL_W-1:0]    out_entry,
  input  wire                                out_last,
  output int                                 fail_count,
  output int                                 pending
);
  import ola_pkg::*;

  // listed entries of a dump carry the same code as a successful append
  localparam logic [STATUS_W-1:0] ST_LISTED = ST_APPENDED;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] entry;
    logic                    last;
  } list_word_t;

  list_word_t              expected_words[$];
  logic signed [VAL_W-1:0] shadow_list[$];
  int                      mismatch_total = 0;
  int                      words_waiting = 0;

  assign fail_count = mismatch_total;
  assign pending    = words_waiting;

  function automatic list_word_t make_word(input logic [STATUS_W-1:0] status,
                                           input logic signed [VAL_W-1:0] entry,
                                           input logic last);
    list_word_t w;
    w.status = status;
    w.entry  = entry;
    w.last   = last;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
    $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
    mismatch_total++;
  endtask

  // apply one accepted request to the shadow list and queue its result words
  task automatic predict_list_op(input logic [KIND_W-1:0] kind,
                                 input logic signed [VAL_W-1:0] value);
    int hit;
    int n;
    hit = -1;
    n   = shadow_list.size();
    case (kind)
      KIND_APPEND: begin
        if (n >= LIST_DEPTH) begin
          expected_words.push_back(make_word(ST_FULL, value, 1'b1));
        end else begin
          shadow_list.push_back(value);
          expected_words.push_back(make_word(ST_APPENDED, value, 1'b1));
        end
      end
      KIND_REMOVE: begin
        if (n == 0) begin
          expected_words.push_back(make_word(ST_EMPTY, value, 1'b1));
        end else begin
          // first match only, later duplicates stay
          for (int i = 0; i < n; i++)
            if (hit < 0 && shadow_list[i] == value) hit = i;
          if (hit >= 0) begin
            shadow_list.delete(hit);
            expected_words.push_back(make_word(ST_REMOVED, value, 1'b1));
          end else begin
            expected_words.push_back(make_word(ST_NOT_FOUND, value, 1'b1));
          end
        end
      end
      KIND_DUMP: begin
        if (n == 0) begin
          expected_words.push_back(make_word(ST_EMPTY, value, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            expected_words.push_back(make_word(ST_LISTED, shadow_list[i], i == n - 1));
        end
      end
      default: begin
        // unused kind code: no word, no change
      end
    endcase
  endtask

  // compare one handed-out word with the oldest expectation
  task automatic check_word();
    list_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with none expected", '0, out_entry);
    end else begin
      want = expected_words.pop_front();
      if (out_status !== want.status)
        report_mismatch("status", VAL_W'(want.status), VAL_W'(out_status));
      if (out_entry !== want.entry) report_mismatch("entry", want.entry, out_entry);
      if (out_last !== want.last)
        report_mismatch("last", VAL_W'(want.last), VAL_W'(out_last));
    end
  endtask

  // results first, so a word at the same edge never meets a fresh expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) predict_list_op(in_kind, in_value);
      words_waiting = expected_words.size();
    end
  end

endmodule

// File: verif/testbench.sv
// top of the ordered list testbench: clock, reset, request stimulus, result stall
// pattern, idle watchdog and verdict; checking is done in ordered_list_checker
// depends on ola_pkg, ordered_list_append_remove and ordered_list_checker
module testbench;
  import ola_pkg::*;

  localparam int DEPTH      = LIST_DEPTH_DEF;
  localparam int IDLE_LIMIT = 3000;
  // kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [KIND_W-1:0]       in_kind;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     out_status;
  logic signed [VAL_W-1:0] out_entry;
  logic                    out_last;
  int                      fail_count;
  int                      pending;
  int                      idle_cycles = 0;
  logic                    calm = 1'b0;
  logic signed [VAL_W-1:0] value_pool[6];

  ordered_list_append_remove #(.LIST_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_entry(out_entry), .out_last(out_last)
  );

  ordered_list_checker #(.LIST_DEPTH(DEPTH)) list_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_entry(out_entry), .out_last(out_last),
    .fail_count(fail_count), .pending(pending)
  );

  // clock, period 8
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ordered_list_append_remove verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // pool values give remove something to hit, the rest is fully random
  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // one request word: present at the falling edge, hold until accepted
  task automatic send(input logic [KIND_W-1:0] kind, input logic signed [VAL_W-1:0] value);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
  endtask

  // stop sending until every expected word has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic mixed_op(input int append_below, input int remove_below);
    int r;
    r = $urandom_range(0, 99);
    if (r < append_below) send(KIND_APPEND, pick_value());
    else if (r < remove_below) send(KIND_REMOVE, pick_value());
    else if (r < 96) send(KIND_DUMP, $urandom);
    else send(KIND_NONE, $urandom);
  endtask

  // result side stall pattern
  initial begin
    int run;
    int hold;
    int r;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run = calm ? 8 : (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6));
      repeat (run) @(negedge clk) out_stall <= 1'b0;
      if (!calm) begin
        r    = $urandom_range(0, 99);
        hold = (r < 70) ? $urandom_range(1, 2) :
               (r < 95) ? $urandom_range(3, 8) : $urandom_range(20, 40);
        repeat (hold) @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    in_valid = 1'b0;
    in_kind  = KIND_APPEND;
    in_value = '0;
    rst_n    = 1'b0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    for (int i = 3; i < 6; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // empty list cases and the ignored kind
    send(KIND_DUMP, $urandom);
    send(KIND_REMOVE, 32'sh0000_1234);
    send(KIND_NONE, $urandom);
    // extremes and a duplicate
    send(KIND_APPEND, 32'sh8000_0000);
    send(KIND_APPEND, 32'sh7fff_ffff);
    send(KIND_APPEND, '0);
    send(KIND_APPEND, -32'sd1);
    send(KIND_APPEND, 32'sh7fff_ffff);
    send(KIND_DUMP, $urandom);
    // miss, first of duplicates, head, tail twice, last one
    send(KIND_REMOVE, 32'sh0000_1234);
    send(KIND_REMOVE, 32'sh7fff_ffff);
    send(KIND_REMOVE, 32'sh8000_0000);
    send(KIND_DUMP, $urandom);
    send(KIND_REMOVE, 32'sh7fff_ffff);
    send(KIND_REMOVE, -32'sd1);
    send(KIND_REMOVE, '0);
    send(KIND_DUMP, $urandom);
    send(KIND_REMOVE, '0);
    drain_results();

    // fill past capacity, dump a full list, then churn at the full edge
    repeat (DEPTH + 2) send(KIND_APPEND, pick_value());
    send(KIND_DUMP, $urandom);
    send(KIND_REMOVE, pick_value());
    send(KIND_APPEND, pick_value());
    send(KIND_APPEND, pick_value());

    // mixed rounds, alternating growth and shrink bias
    for (int round = 0; round < 5; round++) begin
      calm = (round == 3);
      for (int i = 0; i < 10; i++) begin
        if (round % 2 == 1) mixed_op(20, 70);
        else mixed_op(50, 80);
      end
      if (round == 4) drain_results();
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ordered_list_append_remove verification clean");
    else
      $display("ordered_list_append_remove verification failed");
    $finish;
  end

endmodule
